@@ hw/rtl/sha_pkg.sv @@
// Shared types, constants and round table for the SHA-256 stream hash unit
`timescale 1ns / 1ps
package sha_pkg;

	typedef struct packed {
		logic       finish;
		logic [7:0] data;
	} item_t;

	localparam logic [31:0] IV [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
			6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
			6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
			6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
			6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
			6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
			6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
			6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
			6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
			6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
			6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
			6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
			6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
			6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
			6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
			6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
			6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
			6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
			6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
			6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
			6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
			6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
			6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
			6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
			6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
			6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
			6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
			6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
			6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
			6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] ror(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

endpackage

@@ hw/rtl/sha_front.sv @@
// Input queue: accepts and classifies items ahead of the hash engine
`timescale 1ns / 1ps
module sha_front import sha_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       in_cmd,
	input  logic [7:0] in_data,
	output logic       q_valid,
	input  logic       q_pop,
	output item_t      q_item
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          push, pop;

	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{finish: in_cmd, data: in_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

@@ hw/rtl/sha_back.sv @@
// Hash engine: block buffer, padding, 64-round compression and digest output
`timescale 1ns / 1ps
module sha_back import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  item_t       q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_word,
	output logic [2:0]  out_index,
	output logic        out_last
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PAD  = 3'd1;
	localparam logic [2:0] S_RND  = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]   state_q;
	logic [511:0] blk_q;
	logic [31:0]  h_q [8];
	logic [31:0]  r_q [8];
	logic [5:0]   fill_q;
	logic [5:0]   rnd_q;
	logic [60:0]  total_q;
	logic [63:0]  bits_q;
	logic         pad_q;
	logic         len_q;
	logic [2:0]   idx_q;

	logic [31:0] w0, w1, w9, w14, s0, s1, new_w;
	logic [31:0] big1, ch, t1, big0, maj;
	logic [7:0]  pad_byte;
	logic [5:0]  len_sel;

	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];
	assign s0  = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
	assign s1  = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
	assign new_w = w0 + s0 + w9 + s1;

	assign big1 = ror(r_q[4], 6) ^ ror(r_q[4], 11) ^ ror(r_q[4], 25);
	assign ch   = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
	assign t1   = r_q[7] + big1 + ch + round_k(rnd_q) + w0;
	assign big0 = ror(r_q[0], 2) ^ ror(r_q[0], 13) ^ ror(r_q[0], 22);
	assign maj  = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);

	assign len_sel  = 6'd63 - fill_q;
	assign pad_byte = (len_q && fill_q >= LEN_POS) ? bits_q[{len_sel[2:0], 3'b000} +: 8] : 8'h00;

	assign q_pop     = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_word  = h_q[idx_q];
	assign out_index = idx_q;
	assign out_last  = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			h_q     <= IV;
			fill_q  <= '0;
			total_q <= '0;
			pad_q   <= 1'b0;
			len_q   <= 1'b0;
			idx_q   <= '0;
			rnd_q   <= '0;
			bits_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						fill_q <= fill_q + 1'b1;
						if (q_item.finish) begin
							blk_q  <= {blk_q[503:0], PAD_BYTE};
							bits_q <= {total_q, 3'b000};
							pad_q  <= 1'b1;
							len_q  <= (fill_q < LEN_POS);
						end else begin
							blk_q   <= {blk_q[503:0], q_item.data};
							total_q <= total_q + 1'b1;
						end
						if (fill_q == 6'd63) begin
							r_q     <= h_q;
							rnd_q   <= '0;
							state_q <= S_RND;
						end else if (q_item.finish) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					blk_q  <= {blk_q[503:0], pad_byte};
					fill_q <= fill_q + 1'b1;
					if (fill_q == 6'd63) begin
						r_q     <= h_q;
						rnd_q   <= '0;
						state_q <= S_RND;
					end
				end
				S_RND: begin
					blk_q <= {blk_q[479:0], new_w};
					r_q[7] <= r_q[6];
					r_q[6] <= r_q[5];
					r_q[5] <= r_q[4];
					r_q[4] <= r_q[3] + t1;
					r_q[3] <= r_q[2];
					r_q[2] <= r_q[1];
					r_q[1] <= r_q[0];
					r_q[0] <= t1 + big0 + maj;
					rnd_q  <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + r_q[i];
					end
					if (!pad_q) begin
						state_q <= S_IDLE;
					end else if (len_q) begin
						idx_q   <= '0;
						state_q <= S_OUT;
					end else begin
						len_q   <= 1'b1;
						state_q <= S_PAD;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd7) begin
							h_q     <= IV;
							fill_q  <= '0;
							total_q <= '0;
							pad_q   <= 1'b0;
							len_q   <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/sha256_stream_hash_unit.sv @@
// Top level of the streaming SHA-256 hash unit
`timescale 1ns / 1ps
// Streaming SHA-256. The slave channel takes one item per handshake: tuser 0
// absorbs the byte in tdata, tuser 1 finishes the message. The master channel
// returns the digest as eight items, word 0 first, tlast on the eighth.
// A queue of QUEUE_DEPTH items sits in front of the engine, so the source can
// run up to QUEUE_DEPTH items ahead while a block is being compressed.
// Bytes are absorbed while the engine is idle. Each full 64-byte block is then
// compressed in 64 rounds at one round per cycle through the single round
// unit and folded into the chaining words; the engine takes no byte from the
// queue meanwhile. A finish takes the padding bytes at one per cycle, over
// up to two blocks, one or two compressions, then the eight digest words.
// Reset empties the queue, loads the initial vector and clears the counts.
// A stalled master channel holds the current word; the queue keeps taking
// items until it fills.
module sha256_stream_hash_unit import sha_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte[7:0]
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast
);
	logic        q_valid, q_pop;
	item_t       q_item;
	logic [31:0] word;
	logic [2:0]  index;

	sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_cmd  (s_tuser),
		.in_data (s_tdata),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	sha_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_word (word),
		.out_index(index),
		.out_last (m_tlast)
	);

	assign m_tdata = {5'b0, index, word};
endmodule
